@@ rtl/core/dss_pkg.sv @@
// Shared types and constants for the disk seek scheduler.
// Depends on nothing; used by dss_pick and disk_seek_scheduler_core.
`default_nettype none
package dss_pkg;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_SCAN  = 2'd2,
    POL_CSCAN = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_START  = 2'd1,
    REG_SWEEP  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_TAKE,
    ST_EMIT
  } state_e;

  localparam int unsigned SumW = 22;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

endpackage
`default_nettype wire

@@ rtl/core/disk_seek_scheduler_core.sv @@
// Top level of the disk seek scheduler: request ring, scan comparator
// and sequencer. Depends on dss_pkg, dss_cell and dss_pick.
//
// Usage: requests arrive on the in_* channel, one per cycle while loading.
// Up to MAX_REQUESTS tracks are kept; more are dropped. A request with
// last_request_i set closes the batch, and the block then emits one result
// per stored request on the out_* channel in the order of the configured
// policy, with step distance, saturating running total and a final mark.
// Each result takes one full rotation of the request ring past the
// comparator, a state to retire the chosen entry (ST_TAKE), and the output
// state (ST_EMIT). The result stays in its register while out_ready_i
// is low; the next scan starts once it is taken. New requests are accepted
// only after the final result of a batch has been taken.
// Configuration writes (cfg_*) are always taken; registers are meant to be
// changed only while the block is idle. Reset empties the ring, clears the
// registers to policy FCFS, start track 0, upward sweep.
`default_nettype none
module disk_seek_scheduler_core #(
  parameter int unsigned MAX_REQUESTS = 32,
  parameter int unsigned TRACK_BITS   = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [1:0]            cfg_index_i,
  input  wire  [TRACK_BITS-1:0] cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [TRACK_BITS-1:0] track_i,
  input  wire                   last_request_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [TRACK_BITS-1:0] served_track_o,
  output logic [TRACK_BITS-1:0] step_distance_o,
  output logic [21:0]           running_total_o,
  output logic                  last_served_o
);

  localparam int unsigned IdxW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned WideW = ((TRACK_BITS > dss_pkg::SumW) ? TRACK_BITS
                                   : dss_pkg::SumW) + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_REQUESTS);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MAX_REQUESTS - 1);

  dss_pkg::state_e state_q, state_d;

  logic [1:0]            policy_q;
  logic [TRACK_BITS-1:0] start_q;
  logic                  sweep_down_q;
  logic [CntW-1:0]       count_q, emitted_q;
  logic [IdxW-1:0]       pos_q;
  logic [TRACK_BITS-1:0] head_q;
  logic [dss_pkg::SumW-1:0] sum_q;

  logic [TRACK_BITS-1:0] out_trk_q, out_dist_q;
  logic [dss_pkg::SumW-1:0] out_sum_q;
  logic                  out_last_q;

  logic [TRACK_BITS-1:0] cell_trk  [MAX_REQUESTS];
  logic                  cell_live [MAX_REQUESTS];

  logic                  in_acc, rot, pick_clear;
  logic [TRACK_BITS-1:0] best_trk, step;
  logic [IdxW-1:0]       best_idx;
  logic [WideW-1:0]      sum_wide;
  logic [dss_pkg::SumW-1:0] sum_next;
  logic [CntW-1:0]       emitted_next;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == dss_pkg::ST_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign rot         = (state_q == dss_pkg::ST_SCAN);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= dss_pkg::POL_FCFS;
      start_q      <= '0;
      sweep_down_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dss_pkg::REG_POLICY: policy_q     <= cfg_data_i[1:0];
        dss_pkg::REG_START:  start_q      <= cfg_data_i;
        dss_pkg::REG_SWEEP:  sweep_down_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request ring: cell 0 is the head seen by the comparator
  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
    localparam int unsigned Nxt = (g + 1) % MAX_REQUESTS;
    dss_cell #(
      .TRACK_BITS(TRACK_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .rot_i      (rot),
      .nxt_track_i(cell_trk[Nxt]),
      .nxt_live_i (cell_live[Nxt]),
      .wr_i       (in_acc && (count_q < CntMax) && (count_q[IdxW-1:0] == IdxW'(g))),
      .wr_track_i (track_i),
      .clr_i      ((state_q == dss_pkg::ST_TAKE) && (best_idx == IdxW'(g))),
      .track_o    (cell_trk[g]),
      .live_o     (cell_live[g])
    );
  end

  assign pick_clear = (state_q != dss_pkg::ST_SCAN);

  dss_pick #(
    .TRACK_BITS(TRACK_BITS),
    .IDX_W     (IdxW)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (pick_clear),
    .en_i        (rot),
    .track_i     (cell_trk[0]),
    .live_i      (cell_live[0]),
    .idx_i       (pos_q),
    .head_i      (head_q),
    .start_i     (start_q),
    .policy_i    (policy_q),
    .sweep_down_i(sweep_down_q),
    .best_track_o(best_trk),
    .best_idx_o  (best_idx)
  );

  // step distance and saturating total
  always_comb begin
    step     = (best_trk > head_q) ? best_trk - head_q : head_q - best_trk;
    sum_wide = WideW'(sum_q) + WideW'(step);
    sum_next = (sum_wide > WideW'(dss_pkg::SumMax)) ? dss_pkg::SumMax
               : sum_wide[dss_pkg::SumW-1:0];
    emitted_next = emitted_q + CntW'(1);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dss_pkg::ST_LOAD: if (in_acc && last_request_i) state_d = dss_pkg::ST_SCAN;
      dss_pkg::ST_SCAN: if (pos_q == IdxLast) state_d = dss_pkg::ST_TAKE;
      dss_pkg::ST_TAKE: state_d = dss_pkg::ST_EMIT;
      dss_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          state_d = out_last_q ? dss_pkg::ST_LOAD : dss_pkg::ST_SCAN;
        end
      end
      default: state_d = dss_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dss_pkg::ST_LOAD;
      count_q   <= '0;
      emitted_q <= '0;
      pos_q     <= '0;
      head_q    <= '0;
      sum_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        dss_pkg::ST_LOAD: begin
          if (in_acc) begin
            if (count_q < CntMax) count_q <= count_q + CntW'(1);
            if (last_request_i) begin
              head_q    <= start_q;
              sum_q     <= '0;
              emitted_q <= '0;
              pos_q     <= '0;
            end
          end
        end
        dss_pkg::ST_SCAN: begin
          pos_q <= (pos_q == IdxLast) ? '0 : pos_q + IdxW'(1);
        end
        dss_pkg::ST_TAKE: begin
          head_q    <= best_trk;
          sum_q     <= sum_next;
          emitted_q <= emitted_next;
        end
        dss_pkg::ST_EMIT: begin
          if (out_ready_i && out_last_q) count_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == dss_pkg::ST_TAKE) begin
      out_trk_q  <= best_trk;
      out_dist_q <= step;
      out_sum_q  <= sum_next;
      out_last_q <= (emitted_next == count_q);
    end
  end

  assign out_valid_o     = (state_q == dss_pkg::ST_EMIT);
  assign served_track_o  = out_trk_q;
  assign step_distance_o = out_dist_q;
  assign running_total_o = out_sum_q;
  assign last_served_o   = out_last_q;

endmodule
`default_nettype wire

@@ rtl/core/dss_cell.sv @@
// One cell of the request ring: a track and its pending flag.
// Depends on nothing; instantiated by disk_seek_scheduler_core.
`default_nettype none
module dss_cell #(
  parameter int unsigned TRACK_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   rot_i,
  input  wire  [TRACK_BITS-1:0] nxt_track_i,
  input  wire                   nxt_live_i,
  input  wire                   wr_i,
  input  wire  [TRACK_BITS-1:0] wr_track_i,
  input  wire                   clr_i,
  output logic [TRACK_BITS-1:0] track_o,
  output logic                  live_o
);

  logic [TRACK_BITS-1:0] track_q;
  logic                  live_q;

  // pending flag: load sets, service clears, rotation hands it on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (wr_i) begin
      live_q <= 1'b1;
    end else if (clr_i) begin
      live_q <= 1'b0;
    end else if (rot_i) begin
      live_q <= nxt_live_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      track_q <= wr_track_i;
    end else if (rot_i) begin
      track_q <= nxt_track_i;
    end
  end

  assign track_o = track_q;
  assign live_o  = live_q;

endmodule
`default_nettype wire

@@ rtl/core/dss_pick.sv @@
// Scan comparator: watches the ring head over one pass and keeps the
// best candidate for the policy. Depends on dss_pkg.
`default_nettype none
module dss_pick #(
  parameter int unsigned TRACK_BITS = 16,
  parameter int unsigned IDX_W      = 5
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   clear_i,
  input  wire                   en_i,
  input  wire  [TRACK_BITS-1:0] track_i,
  input  wire                   live_i,
  input  wire  [IDX_W-1:0]      idx_i,
  input  wire  [TRACK_BITS-1:0] head_i,
  input  wire  [TRACK_BITS-1:0] start_i,
  input  wire  [1:0]            policy_i,
  input  wire                   sweep_down_i,
  output logic [TRACK_BITS-1:0] best_track_o,
  output logic [IDX_W-1:0]      best_idx_o
);

  logic                  a_have_q, b_have_q;
  logic [TRACK_BITS-1:0] a_trk_q, b_trk_q, a_dist_q;
  logic [IDX_W-1:0]      a_idx_q, b_idx_q;
  logic [TRACK_BITS-1:0] span;
  logic                  in_a, in_b, take_a, take_b, sweep;

  // slot A: FCFS / SSTF / first leg of a sweep; slot B: second leg
  always_comb begin
    span   = (track_i > head_i) ? track_i - head_i : head_i - track_i;
    sweep  = (policy_i == dss_pkg::POL_SCAN) || (policy_i == dss_pkg::POL_CSCAN);
    in_a   = 1'b0;
    in_b   = 1'b0;
    take_a = 1'b0;
    take_b = 1'b0;
    case (policy_i)
      dss_pkg::POL_FCFS: begin
        in_a   = 1'b1;
        take_a = !a_have_q;
      end
      dss_pkg::POL_SSTF: begin
        in_a   = 1'b1;
        take_a = !a_have_q || (span < a_dist_q);
      end
      default: begin
        if (!sweep_down_i) begin
          in_a   = (track_i >= start_i);
          in_b   = !in_a;
          take_a = !a_have_q || (track_i < a_trk_q);
          take_b = !b_have_q || ((policy_i == dss_pkg::POL_CSCAN) ?
                   (track_i < b_trk_q) : (track_i > b_trk_q));
        end else begin
          in_a   = (track_i <= start_i);
          in_b   = !in_a;
          take_a = !a_have_q || (track_i > a_trk_q);
          take_b = !b_have_q || ((policy_i == dss_pkg::POL_CSCAN) ?
                   (track_i > b_trk_q) : (track_i < b_trk_q));
        end
      end
    endcase
    take_a = take_a && in_a && live_i && en_i;
    take_b = take_b && in_b && live_i && en_i && sweep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_have_q <= 1'b0;
      b_have_q <= 1'b0;
    end else if (clear_i) begin
      a_have_q <= 1'b0;
      b_have_q <= 1'b0;
    end else begin
      if (take_a) a_have_q <= 1'b1;
      if (take_b) b_have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_a) begin
      a_trk_q  <= track_i;
      a_dist_q <= span;
      a_idx_q  <= idx_i;
    end
    if (take_b) begin
      b_trk_q <= track_i;
      b_idx_q <= idx_i;
    end
  end

  assign best_track_o = a_have_q ? a_trk_q : b_trk_q;
  assign best_idx_o   = a_have_q ? a_idx_q : b_idx_q;

endmodule
`default_nettype wire
